>>> sv/focq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package focq_pkg;

    localparam int STEP_W   = 10;
    localparam int SAMPLE_W = 32;
    localparam int WEIGHT_W = 7;
    localparam int SUM_W    = 64;
    localparam int SCALE_W  = 32;
    localparam int MAX_STEPS = 1024;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_END_MODE  = 2'd0,
        REG_LAST_STEP = 2'd1,
        REG_SCALE     = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        MODE_CLOSED     = 2'd0,
        MODE_OPEN       = 2'd1,
        MODE_OPEN_LEFT  = 2'd2,
        MODE_OPEN_RIGHT = 2'd3
    } t_end_mode;

    typedef enum logic [1:0] {
        STATUS_OK  = 2'd0,
        STATUS_FEW = 2'd1,
        STATUS_SAT = 2'd2
    } t_status;

    localparam logic [STEP_W-1:0] MIN_STEPS_CLOSED = 10'd7;
    localparam logic [STEP_W-1:0] MIN_STEPS_OPEN   = 10'd9;
    localparam logic [STEP_W-1:0] MIN_STEPS_HALF   = 10'd8;

    localparam logic signed [WEIGHT_W-1:0] CLOSED_W [3] = '{7'sd9, 7'sd28, 7'sd23};
    localparam logic signed [WEIGHT_W-1:0] OPEN_W   [4] = '{7'sd0, 7'sd55, -7'sd4, 7'sd33};
    localparam logic signed [WEIGHT_W-1:0] INNER_W       = 7'sd24;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] fwd;
        logic signed [SAMPLE_W-1:0] bwd;
        logic signed [WEIGHT_W-1:0] weight;
        logic                       last;
        logic                       few;
    } t_step_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    sat;
        logic                    few;
    } t_run_end;

    function automatic logic signed [WEIGHT_W-1:0] focq_weight(
        input logic [STEP_W-1:0] s,
        input logic [STEP_W-1:0] d,
        input t_end_mode         mode
    );
        logic lopen;
        logic ropen;
        logic signed [WEIGHT_W-1:0] w;
        lopen = (mode == MODE_OPEN) || (mode == MODE_OPEN_LEFT);
        ropen = (mode == MODE_OPEN) || (mode == MODE_OPEN_RIGHT);
        if (lopen && s <= 10'd3) begin
            w = OPEN_W[s[1:0]];
        end else if (!lopen && s <= 10'd2) begin
            w = CLOSED_W[s[1:0]];
        end else if (ropen && d <= 10'd3) begin
            w = OPEN_W[d[1:0]];
        end else if (!ropen && d <= 10'd2) begin
            w = CLOSED_W[d[1:0]];
        end else begin
            w = INNER_W;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

>>> sv/focq_front.sv
`timescale 1ns / 1ps
`default_nettype none
module focq_front (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_push,
    input  wire logic signed [focq_pkg::SAMPLE_W-1:0] i_fwd_sample,
    input  wire logic signed [focq_pkg::SAMPLE_W-1:0] i_bwd_sample,
    input  focq_pkg::t_end_mode                       i_end_mode,
    input  wire logic [focq_pkg::STEP_W-1:0]          i_last_step,
    input  wire logic                                 i_q_full,
    output logic                                      o_wr,
    output focq_pkg::t_step_item                      o_item
);
    import focq_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic [STEP_W-1:0] s;
    logic [STEP_W-1:0] d;
    logic [STEP_W-1:0] min_steps;
    logic              last;

    always_comb begin
        unique case (i_end_mode) inside
            MODE_CLOSED:                     min_steps = MIN_STEPS_CLOSED;
            MODE_OPEN:                       min_steps = MIN_STEPS_OPEN;
            MODE_OPEN_LEFT, MODE_OPEN_RIGHT: min_steps = MIN_STEPS_HALF;
            default:                         min_steps = MIN_STEPS_HALF;
        endcase
    end

    assign s    = (r_step > i_last_step) ? i_last_step : r_step;
    assign d    = i_last_step - s;
    assign last = (s == i_last_step);
    assign o_wr = i_push && !i_q_full;

    always_comb begin
        o_item.fwd    = i_fwd_sample;
        o_item.bwd    = i_bwd_sample;
        o_item.weight = focq_weight(s, d, i_end_mode);
        o_item.last   = last;
        o_item.few    = last && (i_last_step < min_steps);
    end

    assign n_step = last ? '0 : s + 10'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (o_wr) begin
            r_step <= n_step;
        end
    end

endmodule
`default_nettype wire

>>> sv/focq_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module focq_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_wr,
    input  focq_pkg::t_step_item i_item,
    input  wire logic            i_rd,
    output focq_pkg::t_step_item o_head,
    output focq_pkg::t_queue_stat o_stat
);
    import focq_pkg::*;

    t_step_item       r_mem [QDEPTH];
    logic [QAW-1:0]   r_wp;
    logic [QAW-1:0]   r_rp;
    logic [QAW:0]     r_cnt;
    logic             do_wr;
    logic             do_rd;

    assign o_stat.full  = (r_cnt == (QAW+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign do_wr  = i_wr && !o_stat.full;
    assign do_rd  = i_rd && !o_stat.empty;
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/focq_accum.sv
`timescale 1ns / 1ps
`default_nettype none
module focq_accum (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  focq_pkg::t_step_item i_head,
    input  wire logic            i_q_empty,
    output logic                 o_rd,
    input  wire logic            i_scale_rdy,
    output logic                 o_end_vld,
    output focq_pkg::t_run_end   o_end
);
    import focq_pkg::*;

    localparam int EXACT_W = SUM_W + WEIGHT_W;
    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    logic                        r_p_vld;
    logic signed [SUM_W-1:0]     r_prod;
    logic signed [WEIGHT_W-1:0]  r_p_w;
    logic                        r_p_last;
    logic                        r_p_few;

    logic                        r_t_vld;
    logic signed [SUM_W-1:0]     r_term;
    logic                        r_t_sat;
    logic                        r_t_last;
    logic                        r_t_few;

    logic signed [SUM_W-1:0]     r_sum;
    logic                        r_sat;

    logic                        adv;
    logic signed [EXACT_W-1:0]   exact;
    logic                        term_ovf;
    logic signed [SUM_W-1:0]     term;
    logic signed [SUM_W:0]       sum_wide;
    logic                        sum_ovf;
    logic signed [SUM_W-1:0]     n_sum;

    assign adv  = !r_t_vld || !r_t_last || i_scale_rdy;
    assign o_rd = adv && !i_q_empty;

    assign exact    = EXACT_W'(r_prod) * EXACT_W'(r_p_w);
    assign term_ovf = (exact[EXACT_W-1:SUM_W-1] != '0) && (exact[EXACT_W-1:SUM_W-1] != '1);
    assign term     = term_ovf ? (exact[EXACT_W-1] ? SUM_MIN : SUM_MAX) : exact[SUM_W-1:0];

    assign sum_wide = {r_sum[SUM_W-1], r_sum} + {r_term[SUM_W-1], r_term};
    assign sum_ovf  = sum_wide[SUM_W] != sum_wide[SUM_W-1];
    assign n_sum    = sum_ovf ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];

    assign o_end_vld = r_t_vld && r_t_last && i_scale_rdy;
    always_comb begin
        o_end.sum = n_sum;
        o_end.sat = r_sat || r_t_sat || sum_ovf;
        o_end.few = r_t_few;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod   <= SUM_W'(i_head.fwd) * SUM_W'(i_head.bwd);
            r_p_w    <= i_head.weight;
            r_p_last <= i_head.last;
            r_p_few  <= i_head.few;
            r_term   <= term;
            r_t_sat  <= term_ovf;
            r_t_last <= r_p_last;
            r_t_few  <= r_p_few;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_t_vld <= 1'b0;
            r_sum   <= '0;
            r_sat   <= 1'b0;
        end else if (adv) begin
            r_p_vld <= !i_q_empty;
            r_t_vld <= r_p_vld;
            if (r_t_vld) begin
                if (r_t_last) begin
                    r_sum <= '0;
                    r_sat <= 1'b0;
                end else begin
                    r_sum <= n_sum;
                    r_sat <= r_sat || r_t_sat || sum_ovf;
                end
            end
        end
    end

endmodule
`default_nettype wire

>>> sv/focq_scale.sv
`timescale 1ns / 1ps
`default_nettype none
module focq_scale (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_end_vld,
    input  focq_pkg::t_run_end                       i_end,
    input  wire logic signed [focq_pkg::SCALE_W-1:0] i_scale_factor,
    output logic                                     o_rdy,
    input  wire logic                                i_pop,
    output logic                                     o_empty,
    output logic signed [focq_pkg::SAMPLE_W-1:0]     o_density,
    output focq_pkg::t_status                        o_status
);
    import focq_pkg::*;

    localparam int HALF_W = SUM_W / 2;
    localparam int PROD_W = HALF_W + SCALE_W;
    localparam int FULL_W = SUM_W + SCALE_W;
    localparam int FRAC   = 44;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABS,
        S_LO,
        S_HI,
        S_RND
    } t_state;

    t_state                      r_state;
    logic signed [SUM_W-1:0]     r_sum;
    logic signed [SCALE_W-1:0]   r_sc;
    logic                        r_sat;
    logic                        r_few;
    logic [SUM_W-1:0]            r_mag_a;
    logic [SCALE_W-1:0]          r_mag_b;
    logic                        r_neg;
    logic [PROD_W-1:0]           r_plo;
    logic [PROD_W-1:0]           r_phi;
    logic                        r_out_vld;
    logic signed [SAMPLE_W-1:0]  r_density;
    t_status                     r_status;

    logic [FULL_W-1:0]           full;
    logic [SAMPLE_W-1:0]         q;
    logic                        big;
    logic                        pos_sat;
    logic                        neg_sat;
    logic signed [SAMPLE_W-1:0]  dens;
    t_status                     stat;
    logic                        out_free;

    assign full = {r_phi, {HALF_W{1'b0}}} + FULL_W'(r_plo) + (FULL_W'(1) << (FRAC - 1));
    assign big  = |full[FULL_W-1:FRAC+SAMPLE_W];
    assign q    = full[FRAC+SAMPLE_W-1:FRAC];
    assign pos_sat = !r_neg && (big || q[SAMPLE_W-1]);
    assign neg_sat = r_neg && (big || q > {1'b1, {(SAMPLE_W-1){1'b0}}});

    always_comb begin
        if (r_few) begin
            dens = '0;
            stat = STATUS_FEW;
        end else begin
            if (pos_sat) begin
                dens = {1'b0, {(SAMPLE_W-1){1'b1}}};
            end else if (neg_sat) begin
                dens = {1'b1, {(SAMPLE_W-1){1'b0}}};
            end else if (r_neg) begin
                dens = -q;
            end else begin
                dens = q;
            end
            stat = (r_sat || pos_sat || neg_sat) ? STATUS_SAT : STATUS_OK;
        end
    end

    assign out_free  = !r_out_vld || i_pop;
    assign o_rdy     = (r_state == S_IDLE);
    assign o_empty   = !r_out_vld;
    assign o_density = r_density;
    assign o_status  = r_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (i_pop && r_out_vld) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_end_vld) begin
                        r_sum   <= i_end.sum;
                        r_sat   <= i_end.sat;
                        r_few   <= i_end.few;
                        r_sc    <= i_scale_factor;
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    r_mag_a <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
                    r_mag_b <= r_sc[SCALE_W-1] ? SCALE_W'(-r_sc) : SCALE_W'(r_sc);
                    r_neg   <= r_sum[SUM_W-1] != r_sc[SCALE_W-1];
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_plo   <= PROD_W'(r_mag_a[HALF_W-1:0]) * PROD_W'(r_mag_b);
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_phi   <= PROD_W'(r_mag_a[SUM_W-1:HALF_W]) * PROD_W'(r_mag_b);
                    r_state <= S_RND;
                end
                S_RND: begin
                    if (out_free) begin
                        r_density <= dens;
                        r_status  <= stat;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> sv/fourth_order_contour_quadrature.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake         Payload
// steps     in         push / full       i_fwd_sample, i_bwd_sample
// results   out        empty / pop       o_density, o_status
// config    in         i_cfg_we          i_cfg_idx, i_cfg_data
//
// Within a run one step is taken per cycle unless full, through a four-entry queue.
// A run's final step reaches the result register through the queue, r_prod, r_term and
// the scaler states S_ABS, S_LO, S_HI, S_RND, the multiply split in two 32-bit halves.
// A new run may stream in while the previous one is being scaled; its final step waits.
// Reset is synchronous and active low, and clears the step count and the sum.
// A result that is not popped stalls the scaler, then the accumulator, then full.
module fourth_order_contour_quadrature (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  push,
    output logic                                       full,
    input  wire logic signed [focq_pkg::SAMPLE_W-1:0]  i_fwd_sample,
    input  wire logic signed [focq_pkg::SAMPLE_W-1:0]  i_bwd_sample,
    output logic                                       empty,
    input  wire logic                                  pop,
    output logic signed [focq_pkg::SAMPLE_W-1:0]       o_density,
    output logic [1:0]                                 o_status,
    input  wire logic                                  i_cfg_we,
    input  wire logic [focq_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire logic [focq_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import focq_pkg::*;

    t_end_mode                r_end_mode;
    logic [STEP_W-1:0]        r_last_step;
    logic signed [SCALE_W-1:0] r_scale;

    logic          w_wr;
    t_step_item    w_item;
    t_step_item    w_head;
    t_queue_stat   w_qstat;
    logic          w_rd;
    logic          w_scale_rdy;
    logic          w_end_vld;
    t_run_end      w_end;
    t_status       w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_mode  <= MODE_CLOSED;
            r_last_step <= '0;
            r_scale     <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_END_MODE: begin
                    r_end_mode <= t_end_mode'(i_cfg_data[1:0]);
                end
                REG_LAST_STEP: begin
                    if (32'(i_cfg_data[STEP_W-1:0]) >= MAX_STEPS) begin
                        r_last_step <= STEP_W'(MAX_STEPS - 1);
                    end else begin
                        r_last_step <= i_cfg_data[STEP_W-1:0];
                    end
                end
                REG_SCALE: begin
                    r_scale <= i_cfg_data[SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    focq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_fwd_sample (i_fwd_sample),
        .i_bwd_sample (i_bwd_sample),
        .i_end_mode   (r_end_mode),
        .i_last_step  (r_last_step),
        .i_q_full     (w_qstat.full),
        .o_wr         (w_wr),
        .o_item       (w_item)
    );

    focq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_wr),
        .i_item  (w_item),
        .i_rd    (w_rd),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    focq_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_empty   (w_qstat.empty),
        .o_rd        (w_rd),
        .i_scale_rdy (w_scale_rdy),
        .o_end_vld   (w_end_vld),
        .o_end       (w_end)
    );

    focq_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_end_vld      (w_end_vld),
        .i_end          (w_end),
        .i_scale_factor (r_scale),
        .o_rdy          (w_scale_rdy),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_density      (o_density),
        .o_status       (w_status)
    );

    assign full     = w_qstat.full;
    assign o_status = w_status;

    a_few_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && w_status == STATUS_FEW) |-> (o_density == '0))
        else $error("Short run gave a non-zero density.");

    a_handoff : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_end_vld |-> w_scale_rdy)
        else $error("Run end handed over while the scaler was busy.");

    a_queue_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("Queue reports full and empty together.");

    a_pop_only_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd |=> $past(!w_qstat.empty))
        else $error("Queue read while empty.");

endmodule
`default_nettype wire
